@@ rtl/core/lmn_pkg.sv @@
package lmn_pkg;

    // Field widths fixed by the message format
    localparam int CMD_W   = 3;
    localparam int MSG_W   = 16;
    localparam int ID_W    = 4;
    localparam int KIND_W  = 2;
    localparam int CNT4_W  = 4;
    localparam int CFG_A_W = 4;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_LOCAL_REQ = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REPLY     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEER_REQ  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PEER_REL  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PEER_DONE = 3'd4;
    localparam logic [CMD_W-1:0] CMD_LOCAL_REL = 3'd5;

    // Outgoing message kinds
    localparam logic [KIND_W-1:0] SEND_NONE    = 2'd0;
    localparam logic [KIND_W-1:0] SEND_REQ     = 2'd1;
    localparam logic [KIND_W-1:0] SEND_REPLY   = 2'd2;
    localparam logic [KIND_W-1:0] SEND_RELEASE = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_A_W-1:0] REG_NODE_ID    = 4'd0;
    localparam logic [CFG_A_W-1:0] REG_PEER_COUNT = 4'd1;

    // Reset values and limits
    localparam logic [ID_W-1:0]   NODE_ID_RESET = 4'd1;
    localparam logic [CNT4_W-1:0] REPLY_MAX     = 4'd15;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [MSG_W-1:0] msg_stamp;
        logic [ID_W-1:0]  sender;
    } in_item_t;

    typedef struct packed {
        logic [MSG_W-1:0]  stamp_out;
        logic [KIND_W-1:0] send_kind;
        logic [ID_W-1:0]   dest;
        logic              grant;
        logic              queue_full;
    } out_item_t;

    // Queue controls from the sequencer
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic pop;
        logic grow;
    } q_ctrl_t;

endpackage

@@ rtl/core/lmn_queue.sv @@
module lmn_queue
    import lmn_pkg::*;
#(
    parameter int DEPTH   = 16,
    parameter int ENTRY_W = 20
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  q_ctrl_t                      ctrl,
    input  logic [$clog2(DEPTH)-1:0]     rd_pos,
    input  logic [$clog2(DEPTH)-1:0]     wr_pos,
    input  logic [ENTRY_W-1:0]           wr_data,
    output logic [ENTRY_W-1:0]           rd_data,
    output logic [$clog2(DEPTH+1)-1:0]   fill
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]   head_reg;
    logic [CNT_W-1:0]   fill_reg;
    logic [IDX_W:0]     rd_sum;
    logic [IDX_W:0]     wr_sum;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;

    // Position relative to head -> circular address
    always_comb
    begin
        rd_sum = {1'b0, head_reg} + {1'b0, rd_pos};
        wr_sum = {1'b0, head_reg} + {1'b0, wr_pos};
        if (rd_sum >= (IDX_W+1)'(DEPTH))
        begin
            rd_sum = rd_sum - (IDX_W+1)'(DEPTH);
        end
        if (wr_sum >= (IDX_W+1)'(DEPTH))
        begin
            wr_sum = wr_sum - (IDX_W+1)'(DEPTH);
        end
        rd_addr = rd_sum[IDX_W-1:0];
        wr_addr = wr_sum[IDX_W-1:0];
    end

    // Entry storage, registered read
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Head pointer and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (ctrl.pop && fill_reg != '0)
            begin
                head_reg <= (head_reg == IDX_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
                fill_reg <= fill_reg - 1'b1;
            end
            else if (ctrl.grow)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
        end
    end

    assign rd_data = rd_data_reg;
    assign fill    = fill_reg;

endmodule

@@ rtl/core/lamport_mutex_node_top.sv @@
// One node of Lamport mutual exclusion. Each input item is one event (local
// request, reply, peer request, peer release, peer done, local release) and
// gives exactly one result item: the logical clock after the event, the
// message to send, the grant flag and a flag for an insertion dropped on a
// full queue. The request queue lives in a single-port-write, registered-read
// memory kept as a circular buffer, so a pop costs nothing extra. A sorted
// insert walks from the tail toward the head with one shared compare, and
// each entry that moves back takes a read state and a compare state. After
// the accepting edge the sequencer runs an execute state, then the insert
// scan when an entry is inserted (a dropped insert on a full queue skips
// it), a head read and a finish state, which loads the result register once
// the output register is free or being taken. The next item is accepted
// once the sequencer is back in idle, but a result may still wait in the
// output register. Configuration writes are always taken; write them only
// while the node is idle.
module lamport_mutex_node_top
    import lmn_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int STAMP_BITS  = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  in_item_t           in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output out_item_t          out_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CFG_A_W-1:0] cfg_addr,
    input  logic [ID_W-1:0]    cfg_data
);

    localparam int IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int ENTRY_W = STAMP_BITS + ID_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_HEAD_RD,
        ST_FINISH
    } state_t;

    state_t                  state_reg;
    logic [CMD_W-1:0]        cmd_reg;
    logic [STAMP_BITS-1:0]   stamp_reg;
    logic [ID_W-1:0]         sender_reg;
    logic [ENTRY_W-1:0]      ent_reg;
    logic [CNT_W-1:0]        k_reg;
    logic [STAMP_BITS-1:0]   clock_reg;
    logic [CNT4_W-1:0]       reply_count_reg;
    logic [CNT4_W-1:0]       replies_needed_reg;
    logic                    awaiting_reg;
    logic [ID_W-1:0]         node_id_reg;
    logic [KIND_W-1:0]       kind_reg;
    logic [ID_W-1:0]         dest_reg;
    logic                    full_reg;
    logic                    out_valid_reg;
    out_item_t               out_item_reg;

    q_ctrl_t                 q_ctrl;
    logic [IDX_W-1:0]        q_rd_pos;
    logic [IDX_W-1:0]        q_wr_pos;
    logic [ENTRY_W-1:0]      q_wr_data;
    logic [ENTRY_W-1:0]      q_rd_data;
    logic [CNT_W-1:0]        q_fill;

    logic [CNT_W-1:0]        k_minus1;
    logic [STAMP_BITS-1:0]   clock_merged;
    logic [STAMP_BITS-1:0]   clock_inc;
    logic                    ent_before;
    logic                    grant_now;
    logic                    q_is_full;

    lmn_queue #(
        .DEPTH   (QUEUE_DEPTH),
        .ENTRY_W (ENTRY_W)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (q_ctrl),
        .rd_pos  (q_rd_pos),
        .wr_pos  (q_wr_pos),
        .wr_data (q_wr_data),
        .rd_data (q_rd_data),
        .fill    (q_fill)
    );

    // Clock arithmetic and the shared ordering compare
    always_comb
    begin
        clock_inc    = clock_reg + 1'b1;
        clock_merged = ((stamp_reg > clock_reg) ? stamp_reg : clock_reg) + 1'b1;
        // (stamp, id) order is the order of the concatenation
        ent_before   = ent_reg < q_rd_data;
        k_minus1     = k_reg - 1'b1;
        q_is_full    = q_fill == CNT_W'(QUEUE_DEPTH);
        grant_now    = awaiting_reg && (reply_count_reg >= replies_needed_reg)
                       && (q_fill != '0) && (q_rd_data[ID_W-1:0] == node_id_reg);
    end

    // Queue controls from the sequencer state
    always_comb
    begin
        q_ctrl    = '0;
        q_rd_pos  = '0;
        q_wr_pos  = k_reg[IDX_W-1:0];
        q_wr_data = ent_reg;
        unique case (state_reg)
            ST_EXEC:
            begin
                q_ctrl.pop = (cmd_reg == CMD_PEER_REL) || (cmd_reg == CMD_LOCAL_REL);
            end
            ST_SCAN_RD:
            begin
                if (k_reg == '0)
                begin
                    q_ctrl.wr_en = 1'b1;
                    q_ctrl.grow  = 1'b1;
                end
                else
                begin
                    q_ctrl.rd_en = 1'b1;
                    q_rd_pos     = k_minus1[IDX_W-1:0];
                end
            end
            ST_SCAN_CMP:
            begin
                q_ctrl.wr_en = 1'b1;
                if (ent_before)
                begin
                    q_wr_data = q_rd_data;
                end
                else
                begin
                    q_ctrl.grow = 1'b1;
                end
            end
            ST_HEAD_RD:
            begin
                q_ctrl.rd_en = 1'b1;
            end
            default:
            begin
                q_ctrl = '0;
            end
        endcase
    end

    // Sequencer, node state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            clock_reg          <= '0;
            reply_count_reg    <= '0;
            replies_needed_reg <= '0;
            awaiting_reg       <= 1'b0;
            node_id_reg        <= NODE_ID_RESET;
            out_valid_reg      <= 1'b0;
            cmd_reg            <= '0;
            stamp_reg          <= '0;
            sender_reg         <= '0;
            ent_reg            <= '0;
            k_reg              <= '0;
            kind_reg           <= SEND_NONE;
            dest_reg           <= '0;
            full_reg           <= 1'b0;
            out_item_reg       <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg    <= in_item.cmd;
                        stamp_reg  <= STAMP_BITS'(in_item.msg_stamp);
                        sender_reg <= in_item.sender;
                        state_reg  <= ST_EXEC;
                    end
                end

                ST_EXEC:
                begin
                    kind_reg  <= SEND_NONE;
                    dest_reg  <= '0;
                    full_reg  <= 1'b0;
                    k_reg     <= q_fill;
                    state_reg <= ST_HEAD_RD;
                    unique case (cmd_reg)
                        CMD_LOCAL_REQ:
                        begin
                            clock_reg       <= clock_inc;
                            reply_count_reg <= '0;
                            awaiting_reg    <= 1'b1;
                            kind_reg        <= SEND_REQ;
                            ent_reg         <= {clock_inc, node_id_reg};
                            if (q_is_full)
                            begin
                                full_reg <= 1'b1;
                            end
                            else
                            begin
                                state_reg <= ST_SCAN_RD;
                            end
                        end
                        CMD_REPLY:
                        begin
                            clock_reg <= clock_merged;
                            if (reply_count_reg != REPLY_MAX)
                            begin
                                reply_count_reg <= reply_count_reg + 1'b1;
                            end
                        end
                        CMD_PEER_REQ:
                        begin
                            clock_reg <= clock_merged;
                            kind_reg  <= SEND_REPLY;
                            dest_reg  <= sender_reg;
                            ent_reg   <= {stamp_reg, sender_reg};
                            if (q_is_full)
                            begin
                                full_reg <= 1'b1;
                            end
                            else
                            begin
                                state_reg <= ST_SCAN_RD;
                            end
                        end
                        CMD_PEER_REL:
                        begin
                            clock_reg <= clock_merged;
                        end
                        CMD_PEER_DONE:
                        begin
                            if (replies_needed_reg != '0)
                            begin
                                replies_needed_reg <= replies_needed_reg - 1'b1;
                            end
                        end
                        CMD_LOCAL_REL:
                        begin
                            clock_reg    <= clock_inc;
                            awaiting_reg <= 1'b0;
                            kind_reg     <= SEND_RELEASE;
                        end
                        default:
                        begin
                            kind_reg <= SEND_NONE;
                        end
                    endcase
                end

                ST_SCAN_RD:
                begin
                    state_reg <= (k_reg == '0) ? ST_HEAD_RD : ST_SCAN_CMP;
                end

                ST_SCAN_CMP:
                begin
                    if (ent_before)
                    begin
                        // entry moved back one place; keep walking toward head
                        k_reg     <= k_minus1;
                        state_reg <= ST_SCAN_RD;
                    end
                    else
                    begin
                        state_reg <= ST_HEAD_RD;
                    end
                end

                ST_HEAD_RD:
                begin
                    state_reg <= ST_FINISH;
                end

                ST_FINISH:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_item_reg.stamp_out  <= MSG_W'(clock_reg);
                        out_item_reg.send_kind  <= kind_reg;
                        out_item_reg.dest       <= dest_reg;
                        out_item_reg.grant      <= grant_now;
                        out_item_reg.queue_full <= full_reg;
                        out_valid_reg           <= 1'b1;
                        state_reg               <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // Configuration writes
            if (cfg_valid)
            begin
                unique case (cfg_addr)
                    REG_NODE_ID:
                    begin
                        node_id_reg <= cfg_data;
                    end
                    REG_PEER_COUNT:
                    begin
                        replies_needed_reg <= cfg_data;
                    end
                    default:
                    begin
                        node_id_reg <= node_id_reg;
                    end
                endcase
            end
        end
    end

    assign in_ready  = state_reg == ST_IDLE;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign cfg_ready = 1'b1;

endmodule
